@@ rtl/core/shuffled_deck_index_top_defines.svh @@
// Assertion macros for the deck index top level.
`ifndef SHUFFLED_DECK_INDEX_TOP_DEFINES_SVH
`define SHUFFLED_DECK_INDEX_TOP_DEFINES_SVH

// Same-cycle implication, checked on clock, off while reset is high.
`define SDI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off while reset is high.
`define SDI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sdi_pkg.sv @@
// Shared constants and the generator step function for the deck index block.
`timescale 1ns / 1ps
`default_nettype none

package sdi_pkg;

   localparam int unsigned SEED_W        = 32;
   localparam int unsigned YEAR_W        = 16;
   localparam int unsigned DAY_W         = 16;
   localparam int unsigned ENTRY_W       = 9;
   localparam int unsigned REQ_W         = 32;
   localparam int unsigned RSP_W         = 16;
   localparam int unsigned DECK_SIZE_DEF = 366;

   // Remainder unit retires two quotient bits per cycle.
   localparam int unsigned DIV_STEPS = SEED_W / 2;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [SEED_W-1:0] SEED_BASE     = 32'h9e37_79b9;
   localparam logic [SEED_W-1:0] YEAR_MUL      = 32'd2654435761;
   localparam logic [SEED_W-1:0] VERSION_MUL   = 32'd2246822519;
   localparam logic [SEED_W-1:0] VERSION_RESET = 32'd1;

   // One xorshift32 step: shift left 13, right 17, left 5.
   function automatic logic [SEED_W-1:0] xs_next(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/shuffled_deck_index_top.sv @@
// Top level of the daily deck index picker: seeded shuffle over an on-chip deck memory.
`timescale 1ns / 1ps
`default_nettype none
`include "shuffled_deck_index_top_defines.svh"

// Usage:
//   req_* takes one item {year, day_number}; rsp_* returns one item {entry_index}.
//   csr_wen/csr_wdata write pack_version (reset value 1); write only while idle.
//   Per item the block seeds xorshift32 from year and pack_version, fills the
//   deck memory with 0..DECK_SIZE-1, shuffles it top down and reads the entry at
//   the clamped day number. The deck is rebuilt for every item.
//   Per item: seeding in SEED_Y and SEED_V with one shared multiplier, DECK_SIZE
//   fill writes, then per swap a generator step, the remainder unit, a read and
//   two writes on the single write port, then a lookup read.
//   One item is in work at a time; the block returns to idle as it loads the
//   result, so the next item can be taken in the cycle that rsp_tvalid rises.
//   req_tready is high only when no item is in work. The result register lets a
//   new item start while the previous result waits; if it is still held when
//   the next result is ready, the block holds that result until rsp_tready.
//   Reset clears the control state and sets pack_version to 1; the deck memory
//   needs no clearing since it is fully written before any read.

module shuffled_deck_index_top #(
   parameter int unsigned DECK_SIZE = sdi_pkg::DECK_SIZE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sdi_pkg::REQ_W-1:0]   req_tdata,   // [15:0] year, [31:16] day_number
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sdi_pkg::RSP_W-1:0]        rsp_tdata,   // [8:0] entry_index, [15:9] zero
   input  wire logic                        csr_wen,
   input  wire logic [sdi_pkg::SEED_W-1:0]  csr_wdata
);

   localparam int unsigned AW    = $clog2(DECK_SIZE);
   localparam int unsigned DIV_W = $clog2(DECK_SIZE + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DECK_SIZE - 1);
   localparam logic [sdi_pkg::DAY_W:0] DAY_LIMIT = (sdi_pkg::DAY_W + 1)'(DECK_SIZE);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SEED_Y = 4'd1;
   localparam logic [3:0] ST_SEED_V = 4'd2;
   localparam logic [3:0] ST_FILL   = 4'd3;
   localparam logic [3:0] ST_STEP   = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_READ   = 4'd6;
   localparam logic [3:0] ST_SWAP_I = 4'd7;
   localparam logic [3:0] ST_SWAP_J = 4'd8;
   localparam logic [3:0] ST_LOOKUP = 4'd9;
   localparam logic [3:0] ST_LOAD   = 4'd10;

   logic [3:0]                  state_ff, state_in;
   logic [sdi_pkg::SEED_W-1:0]  version_ff;
   logic [sdi_pkg::SEED_W-1:0]  s_ff, s_in;
   logic [sdi_pkg::SEED_W-1:0]  prod_ff;
   logic [sdi_pkg::YEAR_W-1:0]  year_ff;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [AW-1:0]               i_ff, i_in;
   logic [AW-1:0]               j_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sdi_pkg::ENTRY_W-1:0] rsp_entry_ff;

   logic [sdi_pkg::SEED_W-1:0]  mul_a, mul_b, mul_p;
   logic [sdi_pkg::SEED_W-1:0]  seed;
   logic [sdi_pkg::SEED_W-1:0]  s_next;
   logic [sdi_pkg::YEAR_W-1:0]  req_year;
   logic [sdi_pkg::DAY_W-1:0]   req_day;
   logic                        req_fire;
   logic                        rsp_load;
   logic [AW+sdi_pkg::ENTRY_W-1:0] entry_ext;

   logic [AW-1:0] deck_mem [DECK_SIZE];
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_wdata, rd_addr_a;
   logic [AW-1:0] rd_a_ff, rd_b_ff;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_rem;

   assign req_year = req_tdata[sdi_pkg::YEAR_W-1:0];
   assign req_day  = req_tdata[sdi_pkg::YEAR_W +: sdi_pkg::DAY_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Clamp day number to the deck.
   always_comb begin
      if (req_day[sdi_pkg::DAY_W-1]) begin
         pos_in = '0;
      end else if ({1'b0, req_day} >= DAY_LIMIT) begin
         pos_in = LAST_IDX;
      end else begin
         pos_in = AW'(req_day);
      end
   end

   // Shared seed multiplier.
   always_comb begin
      if (state_ff == ST_SEED_Y) begin
         mul_a = {{(sdi_pkg::SEED_W - sdi_pkg::YEAR_W){year_ff[sdi_pkg::YEAR_W-1]}}, year_ff};
         mul_b = sdi_pkg::YEAR_MUL;
      end else begin
         mul_a = version_ff;
         mul_b = sdi_pkg::VERSION_MUL;
      end
      mul_p = mul_a * mul_b;
      seed  = sdi_pkg::SEED_BASE ^ prod_ff ^ mul_p;
   end

   assign s_next    = sdi_pkg::xs_next(s_ff);
   assign div_start = (state_ff == ST_STEP);

   sdi_rem_unit #(
      .DIV_W (DIV_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (s_next),
      .divisor   (DIV_W'(i_ff) + DIV_W'(1)),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign entry_ext = {{sdi_pkg::ENTRY_W{1'b0}}, rd_a_ff};
   assign rsp_load  = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      s_in      = s_ff;
      i_in      = i_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = i_ff;
      rd_addr_a = i_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SEED_Y;
            end
         end
         ST_SEED_Y: begin
            state_in = ST_SEED_V;
         end
         ST_SEED_V: begin
            s_in     = (seed == '0) ? sdi_pkg::SEED_W'(1) : seed;
            i_in     = '0;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (i_ff == LAST_IDX) begin
               state_in = ST_STEP;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_STEP: begin
            s_in     = s_next;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_SWAP_I;
         end
         ST_SWAP_I: begin
            mem_we    = 1'b1;
            mem_wdata = rd_b_ff;
            state_in  = ST_SWAP_J;
         end
         ST_SWAP_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = rd_a_ff;
            if (i_ff == AW'(1)) begin
               state_in = ST_LOOKUP;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_LOOKUP: begin
            mem_re    = 1'b1;
            rd_addr_a = pos_ff;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         version_ff   <= sdi_pkg::VERSION_RESET;
         s_ff         <= '0;
         i_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
         i_ff         <= i_in;
         if (csr_wen) begin
            version_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         year_ff <= req_year;
         pos_ff  <= pos_in;
      end
      if (state_ff == ST_SEED_Y) begin
         prod_ff <= mul_p;
      end
      if (div_done) begin
         j_ff <= div_rem[AW-1:0];
      end
      if (rsp_load) begin
         rsp_entry_ff <= entry_ext[sdi_pkg::ENTRY_W-1:0];
      end
   end

   // Deck memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deck_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= deck_mem[rd_addr_a];
         rd_b_ff <= deck_mem[j_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sdi_pkg::RSP_W - sdi_pkg::ENTRY_W){1'b0}}, rsp_entry_ff};

   `SDI_ASSERT_NEXT(a_accept_starts_seed, req_tvalid && req_tready, state_ff == ST_SEED_Y, "accepted item did not start seeding")
   `SDI_ASSERT_NOW(a_swap_index_nonzero, state_ff == ST_STEP, i_ff != '0, "swap step with index zero")
   `SDI_ASSERT_NOW(a_rem_below_divisor, (state_ff == ST_DIV) && div_done, div_rem <= DIV_W'(i_ff), "remainder not below divisor")

endmodule

`default_nettype wire

@@ rtl/core/sdi_rem_unit.sv @@
// Iterative 32-bit by narrow remainder unit, two restoring steps per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sdi_rem_unit #(
   parameter int unsigned DIV_W = 9
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sdi_pkg::SEED_W-1:0]    dividend,
   input  wire logic [DIV_W-1:0]              divisor,
   output logic                               done,
   output logic [DIV_W-1:0]                   remainder
);

   localparam logic [sdi_pkg::DIV_CNT_W-1:0] CNT_LAST =
      sdi_pkg::DIV_CNT_W'(sdi_pkg::DIV_STEPS - 1);

   logic [sdi_pkg::SEED_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]              rem_ff, rem_in;
   logic [DIV_W-1:0]              div_ff;
   logic [sdi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [DIV_W:0] d_ext;
   logic [DIV_W:0] t1, t2;
   logic [DIV_W-1:0] r1;

   always_comb begin
      d_ext = {1'b0, div_ff};
      t1    = {rem_ff, quo_ff[sdi_pkg::SEED_W-1]};
      r1    = (t1 >= d_ext) ? DIV_W'(t1 - d_ext) : DIV_W'(t1);
      t2    = {r1, quo_ff[sdi_pkg::SEED_W-2]};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_ff << 2;
         rem_in = (t2 >= d_ext) ? DIV_W'(t2 - d_ext) : DIV_W'(t2);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ verif/deck_index_checker.sv @@
// Checker for the deck index block: predicts each entry and compares it with the result stream.
`timescale 1ns / 1ps

module deck_index_checker #(
   parameter int unsigned DECK_SIZE = sdi_pkg::DECK_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [sdi_pkg::REQ_W-1:0]   req_tdata,   // [15:0] year, [31:16] day_number
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [sdi_pkg::RSP_W-1:0]   rsp_tdata,   // [8:0] entry_index, [15:9] zero
   input  logic                        csr_wen,
   input  logic [sdi_pkg::SEED_W-1:0]  csr_wdata,
   output int                          entries_due,
   output int                          mismatches
);

   localparam int unsigned ENTRY_W = sdi_pkg::ENTRY_W;

   logic [ENTRY_W-1:0]        entry_queue [$];
   logic [ENTRY_W-1:0]        wanted_entry;
   logic [sdi_pkg::SEED_W-1:0] pack_version = sdi_pkg::VERSION_RESET;
   int                        step_errors;

   initial begin
      entries_due = 0;
      mismatches  = 0;
   end

   // Rebuild and shuffle the deck for one request, then pick the clamped position.
   function automatic logic [ENTRY_W-1:0] shuffled_entry(input logic [15:0] year,
                                                         input logic [15:0] day,
                                                         input logic [31:0] version);
      logic [31:0] state;
      int unsigned deck [DECK_SIZE];
      int unsigned slot;
      int unsigned held;
      int unsigned pos;
      for (int unsigned n = 0; n < DECK_SIZE; n++) begin
         deck[n] = n;
      end
      state = sdi_pkg::SEED_BASE ^ ({{16{year[15]}}, year} * sdi_pkg::YEAR_MUL)
              ^ (version * sdi_pkg::VERSION_MUL);
      if (state == 32'd0) begin
         state = 32'd1;
      end
      for (int unsigned i = DECK_SIZE - 1; i > 0; i--) begin
         state = state ^ (state << 13);
         state = state ^ (state >> 17);
         state = state ^ (state << 5);
         slot = state % (i + 1);
         held = deck[i];
         deck[i] = deck[slot];
         deck[slot] = held;
      end
      if (day[15]) begin
         pos = 0;
      end else if (day >= DECK_SIZE) begin
         pos = DECK_SIZE - 1;
      end else begin
         pos = 32'(day);
      end
      held = deck[pos];
      return held[ENTRY_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pack_version = sdi_pkg::VERSION_RESET;
         entry_queue.delete();
         entries_due <= 0;
      end else begin
         step_errors = 0;
         if (req_tvalid && req_tready) begin
            entry_queue.push_back(shuffled_entry(req_tdata[15:0], req_tdata[31:16],
                                                 pack_version));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (entry_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, got entry_index %0d",
                        $time, rsp_tdata[ENTRY_W-1:0]);
               step_errors++;
            end else begin
               wanted_entry = entry_queue.pop_front();
               if (rsp_tdata[ENTRY_W-1:0] !== wanted_entry) begin
                  $display("%0t: entry_index mismatch, expected %0d, got %0d",
                           $time, wanted_entry, rsp_tdata[ENTRY_W-1:0]);
                  step_errors++;
               end
               if (rsp_tdata[sdi_pkg::RSP_W-1:ENTRY_W] !== '0) begin
                  $display("%0t: padding mismatch, expected 0x%0h, got 0x%0h",
                           $time, 7'h0, rsp_tdata[sdi_pkg::RSP_W-1:ENTRY_W]);
                  step_errors++;
               end
            end
         end
         // Register writes must come only while idle (not enforced); apply after predicting.
         if (csr_wen) begin
            pack_version = csr_wdata;
         end
         entries_due <= entry_queue.size();
         mismatches  <= mismatches + step_errors;
      end
   end

endmodule

@@ verif/testbench.sv @@
// Top of the deck index testbench: clock, reset, request and result traffic, and the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned DECK_SIZE  = sdi_pkg::DECK_SIZE_DEF;
   localparam int unsigned LONG_HOLD  = 24000;
   localparam int unsigned DRAIN_TAIL = 8100;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [sdi_pkg::REQ_W-1:0]   req_tdata = '0;   // [15:0] year, [31:16] day_number
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [sdi_pkg::RSP_W-1:0]   rsp_tdata;        // [8:0] entry_index, [15:9] zero
   logic                        csr_wen = 1'b0;
   logic [sdi_pkg::SEED_W-1:0]  csr_wdata = '0;

   int   entries_due;
   int   mismatches;
   int   requests_sent = 0;
   int   versions_used = 1;
   bit   no_idle = 1'b0;
   bit   hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   shuffled_deck_index_top #(.DECK_SIZE(DECK_SIZE)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   deck_index_checker #(.DECK_SIZE(DECK_SIZE)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .entries_due (entries_due),
      .mismatches  (mismatches)
   );

   // Offer one request; valid stays high when the next one follows without a gap.
   task automatic offer_request(input logic [15:0] year, input logic [15:0] day);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {day, year};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // Drop valid and hold until every predicted entry has come back.
   task automatic await_entries;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (entries_due != 0);
   endtask

   task automatic write_version(input logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      versions_used++;
   endtask

   // Result side: random stalls per item, one long hold on request.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #32_000_000;
      $display("shuffled_deck_index_top test failed");
      $finish;
   end

   initial begin
      logic [31:0] inverse;
      logic [31:0] zero_seed_version;
      logic [15:0] year;
      logic [15:0] day;

      // Version that cancels the seed to zero for year 2026.
      inverse = sdi_pkg::VERSION_MUL;
      repeat (5) inverse = inverse * (32'd2 - sdi_pkg::VERSION_MUL * inverse);
      zero_seed_version = (sdi_pkg::SEED_BASE ^ (32'd2026 * sdi_pkg::YEAR_MUL)) * inverse;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset version: field extremes and day clamping on both sides.
      offer_request(16'h8000, 16'h8000);
      offer_request(16'h7fff, 16'h7fff);
      offer_request(16'd0, 16'd0);
      offer_request(16'hffff, 16'd365);
      offer_request(16'd2024, 16'd366);
      offer_request(16'd1, 16'hffff);
      offer_request(16'd2025, 16'd1);
      offer_request(16'haaaa, 16'd183);
      await_entries();

      write_version(32'd0);
      offer_request(16'd2024, 16'd0);
      offer_request(16'h8000, 16'd365);
      await_entries();

      write_version(32'hffff_ffff);
      offer_request(16'd2024, 16'd0);
      offer_request(16'h7fff, 16'd100);
      await_entries();

      // Seed collapses to zero and is replaced by one.
      write_version(zero_seed_version);
      offer_request(16'd2026, 16'd0);
      offer_request(16'd2026, 16'd365);
      offer_request(16'd2026, 16'hfffb);
      offer_request(16'd2027, 16'd50);
      await_entries();

      for (int p = 0; p < 4; p++) begin
         write_version($urandom);
         no_idle = (p % 2 == 0);
         // Back up the block behind a stalled result side while requests keep coming.
         if (p == 0) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < 25; n++) begin
            year = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1900, 2100))
                                               : 16'($urandom);
            case ($urandom_range(0, 9))
               7:       day = 16'($urandom);
               8:       day = 16'($urandom_range(DECK_SIZE, 32767));
               9:       day = 16'(-$urandom_range(1, 32768));
               default: day = 16'($urandom_range(0, DECK_SIZE - 1));
            endcase
            offer_request(year, day);
            if (p == 2 && n == 12) begin
               await_entries();
            end
         end
         await_entries();
      end

      repeat (DRAIN_TAIL) @(posedge clock);
      $display("Ran %0d requests under %0d pack versions: field extremes, zero seed,",
               requests_sent, versions_used);
      $display("day clamping both ways, and a long result stall that backed up requests.");
      if (mismatches == 0 && entries_due == 0) begin
         $display("shuffled_deck_index_top test passed");
      end else begin
         $display("shuffled_deck_index_top test failed");
      end
      $finish;
   end

endmodule
